// File: rtl/ksp_pkg.sv
// ----------------------------------------------------------------------------
// ksp_pkg
// Shared types, constants and CORDIC table of the kinematic state predictor.
// ----------------------------------------------------------------------------
package ksp_pkg;

  localparam int MAX_STEPS_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_ITERS  = 30;
  localparam int ITER_W        = 5;
  localparam int STEP_RESET    = 100;
  localparam logic [63:0] CORDIC_GAIN = 64'd652032874;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_CLAMPED = 2'd2;

  localparam logic [0:0] REG_STEP_MS = 1'd0;

  // datapath operations
  typedef enum logic [3:0] {
    OP_LOAD    = 4'd0,
    OP_VM      = 4'd1,
    OP_D       = 4'd2,
    OP_DV      = 4'd3,
    OP_MID     = 4'd4,
    OP_TH      = 4'd5,
    OP_REDUCE  = 4'd6,
    OP_FOLD    = 4'd7,
    OP_ROT     = 4'd8,
    OP_CSCALE  = 4'd9,
    OP_X       = 4'd10,
    OP_Y       = 4'd11,
    OP_IDLE    = 4'd12
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ITER_W-1:0] iter;
  } ksp_cmd_t;

  typedef struct packed {
    logic red_done;
  } ksp_stat_t;

  function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0:  r = 32'h3243F6A8;  5'd1:  r = 32'h1DAC6705;
        5'd2:  r = 32'h0FADBAFC;  5'd3:  r = 32'h07F56EA6;
        5'd4:  r = 32'h03FEAB76;  5'd5:  r = 32'h01FFD55B;
        5'd6:  r = 32'h00FFFAAA;  5'd7:  r = 32'h007FFF55;
        5'd8:  r = 32'h003FFFEA;  5'd9:  r = 32'h001FFFFD;
        5'd10: r = 32'h000FFFFF;  5'd11: r = 32'h0007FFFF;
        5'd12: r = 32'h0003FFFF;  5'd13: r = 32'h0001FFFF;
        5'd14: r = 32'h0000FFFF;  5'd15: r = 32'h00007FFF;
        5'd16: r = 32'h00003FFF;  5'd17: r = 32'h00001FFF;
        5'd18: r = 32'h00000FFF;  5'd19: r = 32'h000007FF;
        5'd20: r = 32'h000003FF;  5'd21: r = 32'h000001FF;
        5'd22: r = 32'h000000FF;  5'd23: r = 32'h0000007F;
        5'd24: r = 32'h0000003F;  5'd25: r = 32'h0000001F;
        5'd26: r = 32'h0000000F;  5'd27: r = 32'h00000008;
        5'd28: r = 32'h00000004;  5'd29: r = 32'h00000002;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: rtl/ksp_if.sv
// ----------------------------------------------------------------------------
// ksp_in_if / ksp_out_if
// Valid/ready channels carrying one request or one prediction result.
// ----------------------------------------------------------------------------
interface ksp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] curvature;
  logic signed [31:0] speed;
  logic signed [31:0] accel;
  logic [15:0]        horizon_ms;
  modport source(output valid, pos_x, pos_y, heading, curvature, speed, accel,
                 horizon_ms, input ready);
  modport sink(input valid, pos_x, pos_y, heading, curvature, speed, accel,
               horizon_ms, output ready);
endinterface

interface ksp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] next_x;
  logic signed [31:0] next_y;
  logic signed [31:0] next_heading;
  logic signed [31:0] next_speed;
  logic [8:0]         steps_done;
  logic [1:0]         status;
  modport source(output valid, next_x, next_y, next_heading, next_speed,
                 steps_done, status, input ready);
  modport sink(input valid, next_x, next_y, next_heading, next_speed,
               steps_done, status, output ready);
endinterface

// File: rtl/ksp_datapath.sv
// ----------------------------------------------------------------------------
// ksp_datapath
// State registers, a shared step multiplier and the shift-add CORDIC datapath.
// ----------------------------------------------------------------------------
module ksp_datapath import ksp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  ksp_cmd_t           cmd,
  output ksp_stat_t          stat,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_th,
  input  logic signed [31:0] in_kap,
  input  logic signed [31:0] in_v,
  input  logic signed [31:0] in_a,
  input  logic signed [31:0] dt,
  output logic signed [31:0] x,
  output logic signed [31:0] y,
  output logic signed [31:0] th,
  output logic signed [31:0] v
);
  localparam logic signed [63:0] TWO_PI_Q =
    64'sd26986075409 + (64'sd1 <<< (31 - FRAC_BITS)) >>> (32 - FRAC_BITS);
  localparam logic signed [63:0] PI_Q =
    64'sd13493037705 + (64'sd1 <<< (31 - FRAC_BITS)) >>> (32 - FRAC_BITS);
  localparam logic signed [63:0] HALF_PI_Q =
    64'sd6746518852 + (64'sd1 <<< (31 - FRAC_BITS)) >>> (32 - FRAC_BITS);
  // floor(2^32 / TWO_PI_Q): quotient estimate is exact or one low
  localparam logic [31:0] RED_RECIP = 32'((64'd1 << 32) / 64'(TWO_PI_Q));

  logic signed [31:0] kap, a, vm, d, dv, mid;
  logic signed [33:0] r;
  logic               neg;
  logic signed [63:0] cx, cy, cz;
  logic signed [31:0] c, s;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] xs, ys;

  // reduction: quotient estimate from mid, then one subtract and one fixup
  logic [31:0] mid_mag, r_mag, rq, rem, rem_fix;
  logic [63:0] rq_prod;
  logic        red_ok;
  assign red_ok = (r < 34'(TWO_PI_Q)) && (r > -34'(TWO_PI_Q));
  assign stat.red_done = red_ok;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_VM:  begin ma = a;   mb = dt;  end
      OP_D:   begin ma = dt;  mb = vm;  end
      OP_DV:  begin ma = dt;  mb = v;   end
      OP_MID: begin ma = dv;  mb = kap; end
      OP_TH:  begin ma = d;   mb = kap; end
      OP_X:   begin ma = d;   mb = c;   end
      OP_Y:   begin ma = d;   mb = s;   end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
    xs = cx >>> cmd.iter;
    ys = cy >>> cmd.iter;
    mid_mag = mid[31] ? (32'(~mid) + 32'd1) : 32'(mid);
    rq_prod = 64'(mid_mag) * 64'(RED_RECIP);
    r_mag = r[33] ? 32'(-r) : 32'(r);
    rem = 32'(64'(r_mag) - 64'(rq) * 64'(TWO_PI_Q));
    rem_fix = (rem >= 32'(TWO_PI_Q)) ? rem - 32'(TWO_PI_Q) : rem;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        x <= in_x; y <= in_y; th <= in_th; kap <= in_kap; v <= in_v; a <= in_a;
      end
      OP_VM:  vm <= sat32(66'(v) + 66'(prod >>> (FRAC_BITS + 1)));
      OP_D:   d <= sat32(66'(prod >>> FRAC_BITS));
      OP_DV:  dv <= sat32(66'(prod >>> FRAC_BITS));
      OP_MID: begin
        mid <= sat32(66'(th) + 66'(sat32(66'(prod >>> (FRAC_BITS + 1)))));
        r <= 34'(mid);
      end
      OP_TH: begin
        th <= sat32(66'(th) + 66'(sat32(66'(prod >>> FRAC_BITS))));
        r <= 34'(mid);
        rq <= rq_prod[63:32];
      end
      OP_REDUCE: begin
        if (!red_ok) r <= r[33] ? -34'(rem_fix) : 34'(rem_fix);
      end
      OP_FOLD: begin
        logic signed [33:0] q;
        logic               n;
        q = r;
        n = 1'b0;
        if (q > 34'(PI_Q)) q = q - 34'(TWO_PI_Q);
        if (q < -34'(PI_Q)) q = q + 34'(TWO_PI_Q);
        if (q > 34'(HALF_PI_Q)) begin q = q - 34'(PI_Q); n = 1'b1; end
        else if (q < -34'(HALF_PI_Q)) begin q = q + 34'(PI_Q); n = 1'b1; end
        neg <= n;
        cz <= 64'(q) <<< (30 - FRAC_BITS);
        cx <= CORDIC_GAIN;
        cy <= '0;
      end
      OP_ROT: begin
        if (!cz[63]) begin
          cx <= cx - ys; cy <= cy + xs; cz <= cz - 64'(atan_entry(cmd.iter));
        end else begin
          cx <= cx + ys; cy <= cy - xs; cz <= cz + 64'(atan_entry(cmd.iter));
        end
      end
      OP_CSCALE: begin
        c <= neg ? -32'(cx >>> (30 - FRAC_BITS)) : 32'(cx >>> (30 - FRAC_BITS));
        s <= neg ? -32'(cy >>> (30 - FRAC_BITS)) : 32'(cy >>> (30 - FRAC_BITS));
      end
      OP_X: x <= sat32(66'(x) + 66'(prod >>> FRAC_BITS));
      OP_Y: begin
        y <= sat32(66'(y) + 66'(prod >>> FRAC_BITS));
        v <= vm;
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/ksp_ctrl.sv
// ----------------------------------------------------------------------------
// ksp_ctrl
// Sequencer: step counting by time accumulation, per-step op sequence.
// ----------------------------------------------------------------------------
module ksp_ctrl import ksp_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] horizon,
  input  logic [9:0]  step_ms,
  output logic        busy,
  output logic        done,
  input  logic        out_taken,
  output ksp_cmd_t    cmd,
  input  ksp_stat_t   stat,
  output logic [16:0] n,
  output logic [1:0]  status,
  output logic [15:0] dt_ms
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_COUNT = 9'b000000010,
    S_DT    = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_RED   = 9'b000010000,
    S_FOLD  = 9'b000100000,
    S_ROT   = 9'b001000000,
    S_POS   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t      state;
  logic [16:0] t;
  logic [16:0] k;
  logic [15:0] hor;
  logic [2:0]  sub;
  logic [ITER_W-1:0] iter;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    cmd.op = OP_IDLE;
    cmd.iter = iter;
    unique case (state)
      S_IDLE: cmd.op = start ? OP_LOAD : OP_IDLE;
      S_MUL: begin
        unique case (sub)
          3'd0: cmd.op = OP_VM;
          3'd1: cmd.op = OP_D;
          3'd2: cmd.op = OP_DV;
          3'd3: cmd.op = OP_MID;
          default: cmd.op = OP_TH;
        endcase
      end
      S_RED:  cmd.op = OP_REDUCE;
      S_FOLD: cmd.op = OP_FOLD;
      S_ROT:  cmd.op = OP_ROT;
      S_POS: begin
        unique case (sub)
          3'd0: cmd.op = OP_CSCALE;
          3'd1: cmd.op = OP_X;
          default: cmd.op = OP_Y;
        endcase
      end
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sub <= '0;
      iter <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          hor <= horizon;
          n <= '0;
          k <= '0;
          sub <= '0;
          if (horizon == 16'd0) begin
            status <= ST_ZERO;
            state <= S_DONE;
          end else begin
            status <= ST_OK;
            dt_ms <= (step_ms == 10'd0) ? 16'd1 :
                     ((16'(step_ms) > horizon) ? horizon : 16'(step_ms));
            t <= '0;
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (t + 17'(dt_ms) <= 17'(hor)) begin
            t <= t + 17'(dt_ms);
            n <= n + 17'd1;
          end else begin
            if (n > 17'(MAX_STEPS)) begin
              n <= 17'(MAX_STEPS);
              status <= ST_CLAMPED;
            end
            state <= S_DT;
          end
        end
        S_DT: state <= (k < n) ? S_MUL : S_DONE;
        S_MUL: begin
          // OP_TH also latches mid into the reducer
          if (sub == 3'd4) begin sub <= '0; state <= S_RED; end
          else sub <= sub + 3'd1;
        end
        S_RED: if (stat.red_done) state <= S_FOLD;
        S_FOLD: begin iter <= '0; state <= S_ROT; end
        S_ROT: begin
          if (iter == ITER_W'(CORDIC_ITERS - 1)) state <= S_POS;
          else iter <= iter + 1'b1;
        end
        S_POS: begin
          if (sub == 3'd2) begin
            sub <= '0;
            k <= k + 17'd1;
            state <= S_DT;
          end else sub <= sub + 3'd1;
        end
        S_DONE: if (out_taken) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_DT) |-> k <= n)
    else $error("step index beyond count");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> iter < ITER_W'(CORDIC_ITERS))
    else $error("cordic iteration out of range");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> status != ST_ZERO)
    else $error("stepping on zero horizon");
endmodule

// File: rtl/kinematic_state_predictor.sv
// ----------------------------------------------------------------------------
// kinematic_state_predictor
// Constant-curvature motion prediction in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage: a request on req (pose, curvature, speed, accel, horizon_ms) is
// taken while the block is idle; one result appears on rsp and is held until
// taken. Step length is the APB register step_ms (offset 0, reset 100).
// Sequence: steps are first counted by accumulating the step length up to the
// horizon, then each step runs a dispatch, 5 multiplies, angle reduction,
// 1 fold, 30 CORDIC iterations and 3 position operations, then the result.
// A zero horizon gives its result the cycle after the request is taken.
// A shared 32x32 multiplier and the iterative CORDIC serialise each step.
// The next request is taken the cycle after the result has been taken.
// Reset returns the sequencer to idle and step_ms to 100. When the receiver
// stalls, the result and the sequencer and datapath state stay put.
// ----------------------------------------------------------------------------
module kinematic_state_predictor import ksp_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ksp_in_if.sink      req,
  ksp_out_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // floor(2^(F+14) / 1000): dt estimate is exact or one low
  localparam logic [63:0] DT_RECIP = (64'd1 << (FRAC_BITS + 14)) / 64'd1000;

  logic [9:0]  step_ms;
  logic        busy, done, start;
  ksp_cmd_t    cmd;
  ksp_stat_t   stat;
  logic [16:0] n;
  logic [1:0]  status;
  logic [15:0] dt_ms;
  logic signed [31:0] dt;
  logic [63:0] dt_num;
  logic [63:0] dt_est_sum;
  logic [31:0] dt_est;
  logic [63:0] dt_rem;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? {22'd0, step_ms} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) step_ms <= 10'(STEP_RESET);
    else if (psel && penable && pwrite && paddr == {REG_STEP_MS, 1'b0} << 0)
      step_ms <= pwdata[9:0];
  end

  // dt = round(dt_ms * 2^F / 1000) by reciprocal multiply and one fixup
  always_comb begin
    dt_num = (64'(dt_ms) << FRAC_BITS) + 64'd500;
    dt_est_sum = ((64'(dt_ms) * DT_RECIP) << FRAC_BITS) + 64'd500 * DT_RECIP;
    dt_est = 32'(dt_est_sum >> (FRAC_BITS + 14));
    dt_rem = dt_num - 64'(dt_est) * 64'd1000;
  end

  always_ff @(posedge clk) begin
    dt <= (dt_rem >= 64'd1000) ? dt_est + 32'd1 : dt_est;
  end

  assign start = req.valid && req.ready;
  assign req.ready = !busy;

  ksp_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk, .rst, .start, .horizon(req.horizon_ms), .step_ms, .busy, .done,
    .out_taken(rsp.valid && rsp.ready), .cmd, .stat, .n, .status, .dt_ms
  );

  ksp_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .cmd, .stat,
    .in_x(req.pos_x), .in_y(req.pos_y), .in_th(req.heading),
    .in_kap(req.curvature), .in_v(req.speed), .in_a(req.accel), .dt,
    .x(rsp.next_x), .y(rsp.next_y), .th(rsp.next_heading), .v(rsp.next_speed)
  );

  assign rsp.valid = done;
  assign rsp.steps_done = n[8:0];
  assign rsp.status = status;
endmodule
